// ----- rtl/sha1_pkg.sv -----
// Types, constants and helper functions shared by the SHA-1 engine modules.
package sha1_pkg;

  localparam int unsigned Rounds     = 80;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned DigWords   = 5;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [DigWords-1:0][31:0] INIT_VECTOR = {
    32'hc3d2_e1f0, 32'h1032_5476, 32'h98ba_dcfe, 32'hefcd_ab89, 32'h6745_2301
  };

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_RND  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    GRP_CH    = 2'd0,
    GRP_PAR_A = 2'd1,
    GRP_MAJ   = 2'd2,
    GRP_PAR_B = 2'd3
  } grp_e;

  typedef struct packed {
    logic load;
    logic step;
    grp_e grp;
  } rnd_ctl_t;

  typedef struct packed {
    logic        push;
    logic        step;
    logic        expand;
    logic [31:0] word;
  } sch_ctl_t;

  typedef logic [DigWords-1:0][31:0] hash_t;

  function automatic logic [31:0] round_k(grp_e g);
    logic [31:0] k;
    case (g)
      GRP_CH:    k = 32'h5a82_7999;
      GRP_PAR_A: k = 32'h6ed9_eba1;
      GRP_MAJ:   k = 32'h8f1b_bcdc;
      GRP_PAR_B: k = 32'hca62_c1d6;
      default:   k = 32'h5a82_7999;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/sha1_sched.sv -----
// Sixteen-word message schedule window held as a shift line with fixed taps.
module sha1_sched (
  input  logic               clk_i,
  input  sha1_pkg::sch_ctl_t ctl_i,
  output logic [31:0]        wr_o
);
  import sha1_pkg::*;

  logic [BlockWords-1:0][31:0] win_q;
  logic [31:0]                 mix;

  assign mix  = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign wr_o = ctl_i.expand ? {mix[30:0], mix[31]} : win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      win_q <= {ctl_i.word, win_q[BlockWords-1:1]};
    end else if (ctl_i.step) begin
      win_q <= {wr_o, win_q[BlockWords-1:1]};
    end
  end

endmodule

// ----- rtl/sha1_round.sv -----
// Shared SHA-1 round unit with the five working variables a to e.
module sha1_round (
  input  logic               clk_i,
  input  sha1_pkg::rnd_ctl_t ctl_i,
  input  sha1_pkg::hash_t    chain_i,
  input  logic [31:0]        wr_i,
  output sha1_pkg::hash_t    work_o
);
  import sha1_pkg::*;

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] f, t;

  always_comb begin
    case (ctl_i.grp)
      GRP_CH:  f = (b_q & c_q) | (~b_q & d_q);
      GRP_MAJ: f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default: f = b_q ^ c_q ^ d_q;
    endcase
    t = {a_q[26:0], a_q[31:27]} + f + e_q + round_k(ctl_i.grp) + wr_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= chain_i[0];
      b_q <= chain_i[1];
      c_q <= chain_i[2];
      d_q <= chain_i[3];
      e_q <= chain_i[4];
    end else if (ctl_i.step) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= t;
    end
  end

  assign work_o = {e_q, d_q, c_q, b_q, a_q};

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// Top level of the SHA-1 engine: sequencer, chaining value, length count, padding.
//
//   channel   dir  tdata (low bit up)                      tlast      role
//   s_axis    in   data_word[31:0] byte_count[34:32]       is_last    message words
//   m_axis    out  digest_word[31:0] word_index[34:32]     last_word  digest H0..H4
//
// A message word is taken while idle; the beat that fills a 16-word block starts
// the rounds on the single round unit, then a feed-forward add. After the final
// beat, padding words enter one per cycle unless a block is compressing, one or
// two more compressions run, then five digest beats leave; no input is taken
// meanwhile. Reset loads the initial vector and clears the word and bit counters.
// A stalled digest beat holds until m_axis_tready_i is high.
module sha1_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // data_word[31:0], byte_count[34:32], zero
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // digest_word[31:0], word_index[34:32], zero
  output logic        m_axis_tlast_o    // last_word
);
  import sha1_pkg::*;

  state_e      state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] len_q, len_d;
  hash_t       chain_q, chain_d;
  logic        pad80_q, pad80_d;
  logic        hi_q, hi_d;
  logic        fin_q, fin_d;
  logic        padm_q, padm_d;

  rnd_ctl_t    rctl;
  sch_ctl_t    sctl;
  hash_t       work;
  logic [31:0] wr;
  logic        in_acc;
  logic [31:0] data;
  logic [2:0]  nb;
  logic [31:0] mask;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign data   = s_axis_tdata_i[31:0];
  assign nb     = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];

  always_comb begin
    case (nb)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'hff00_0000;
      3'd2:    mask = 32'hffff_0000;
      3'd3:    mask = 32'hffff_ff00;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    len_d     = len_q;
    chain_d   = chain_q;
    pad80_d   = pad80_q;
    hi_d      = hi_q;
    fin_d     = fin_q;
    padm_d    = padm_q;
    sctl      = '0;
    rctl.load = 1'b0;
    rctl.step = 1'b0;
    if (rnd_q < 7'd20) begin
      rctl.grp = GRP_CH;
    end else if (rnd_q < 7'd40) begin
      rctl.grp = GRP_PAR_A;
    end else if (rnd_q < 7'd60) begin
      rctl.grp = GRP_MAJ;
    end else begin
      rctl.grp = GRP_PAR_B;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sctl.push = 1'b1;
          if (!s_axis_tlast_i) begin
            sctl.word = data;
            len_d     = len_q + 64'd32;
          end else begin
            len_d   = len_q + {58'd0, nb, 3'b000};
            padm_d  = 1'b1;
            state_d = ST_PAD;
            if (nb == 3'd4) begin
              sctl.word = data;
              pad80_d   = 1'b1;
            end else begin
              sctl.word = (data & mask) | (PAD_WORD >> {nb, 3'b000});
            end
          end
        end
      end
      ST_PAD: begin
        sctl.push = 1'b1;
        if (pad80_q) begin
          sctl.word = PAD_WORD;
          pad80_d   = 1'b0;
        end else if (hi_q) begin
          sctl.word = len_q[31:0];
          fin_d     = 1'b1;
        end else if (cnt_q == 4'd14) begin
          sctl.word = len_q[63:32];
          hi_d      = 1'b1;
        end else begin
          sctl.word = '0;
        end
      end
      ST_RND: begin
        sctl.step   = 1'b1;
        sctl.expand = (rnd_q >= 7'(BlockWords));
        rctl.step   = 1'b1;
        if (rnd_q == 7'(Rounds - 1)) begin
          rnd_d   = '0;
          state_d = ST_ADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < DigWords; i++) begin
          chain_d[i] = chain_q[i] + work[i];
        end
        if (fin_q) begin
          state_d = ST_OUT;
        end else if (padm_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          if (idx_q == 3'(DigWords - 1)) begin
            idx_d   = '0;
            chain_d = INIT_VECTOR;
            len_d   = '0;
            hi_d    = 1'b0;
            fin_d   = 1'b0;
            padm_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sctl.push) begin
      if (cnt_q == 4'(BlockWords - 1)) begin
        cnt_d     = '0;
        rctl.load = 1'b1;
        state_d   = ST_RND;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      chain_q <= INIT_VECTOR;
      pad80_q <= 1'b0;
      hi_q    <= 1'b0;
      fin_q   <= 1'b0;
      padm_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      chain_q <= chain_d;
      pad80_q <= pad80_d;
      hi_q    <= hi_d;
      fin_q   <= fin_d;
      padm_q  <= padm_d;
    end
  end

  sha1_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .wr_o  (wr)
  );

  sha1_round u_round (
    .clk_i   (clk_i),
    .ctl_i   (rctl),
    .chain_i (chain_q),
    .wr_i    (wr),
    .work_o  (work)
  );

  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {5'd0, idx_q, chain_q[idx_q]};
  assign m_axis_tlast_o  = (idx_q == 3'(DigWords - 1));

endmodule

// ----- dv/sha1_digest_checker.sv -----
// Checker for the SHA-1 engine: predicts digests from accepted message beats and compares them.
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,   // data_word[31:0], byte_count[34:32], zero
  input  logic        s_axis_tlast_i,   // is_last
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // digest_word[31:0], word_index[34:32], zero
  input  logic        m_axis_tlast_i,   // last_word
  output int          fail_count_o,
  output int          digest_pending_o
);
  import sha1_pkg::*;

  localparam logic [31:0] K_CH    = 32'h5a82_7999;
  localparam logic [31:0] K_PAR_A = 32'h6ed9_eba1;
  localparam logic [31:0] K_MAJ   = 32'h8f1b_bcdc;
  localparam logic [31:0] K_PAR_B = 32'hca62_c1d6;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  digest_beat_t digest_due_q[$];
  digest_beat_t due_beat;

  logic [31:0] chain_h [DigWords];
  logic [31:0] block_buf [BlockWords];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < DigWords; i++) chain_h[i] = INIT_VECTOR[i];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [BlockWords];
    logic [31:0] a, b, c, d, e, f, k, wr, t;
    grp_e        g;
    for (int i = 0; i < BlockWords; i++) w[i] = block_buf[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < Rounds; r++) begin
      g = grp_e'(r / 20);
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
        w[r % 16] = wr;
      end
      case (g)
        GRP_CH: begin
          f = (b & c) | (~b & d);
          k = K_CH;
        end
        GRP_PAR_A: begin
          f = b ^ c ^ d;
          k = K_PAR_A;
        end
        GRP_MAJ: begin
          f = (b & c) | (b & d) | (c & d);
          k = K_MAJ;
        end
        default: begin
          f = b ^ c ^ d;
          k = K_PAR_B;
        end
      endcase
      t = rotl(a, 5) + f + e + k + wr;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_word(input logic [31:0] w);
    block_buf[block_fill] = w;
    block_fill++;
    if (block_fill == BlockWords) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic void take_message_beat(input logic [31:0] data, input logic [2:0] nbytes,
                                            input logic last);
    int unsigned  n;
    logic [31:0]  keep;
    digest_beat_t beat;
    if (!last) begin
      msg_bits += 64'd32;
      absorb_word(data);
      return;
    end
    n = (nbytes > 3'd4) ? 4 : nbytes;
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      absorb_word(data);
      absorb_word(PAD_WORD);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      absorb_word((data & keep) | (PAD_WORD >> (8 * n)));
    end
    // length no longer fits: flush an extra block
    if (block_fill > 14) begin
      while (block_fill != 0) absorb_word(32'h0);
    end
    while (block_fill < 14) absorb_word(32'h0);
    absorb_word(msg_bits[63:32]);
    absorb_word(msg_bits[31:0]);
    for (int i = 0; i < DigWords; i++) begin
      beat.word  = chain_h[i];
      beat.index = 3'(i);
      beat.last  = (i == DigWords - 1);
      digest_due_q.push_back(beat);
    end
    restart_message();
  endfunction

  initial begin
    fail_count_o     = 0;
    digest_pending_o = 0;
    restart_message();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (digest_due_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: digest beat with none due: expected none, actual %h",
                   $time, m_axis_tdata_i[31:0]);
        end else begin
          due_beat = digest_due_q.pop_front();
          if (m_axis_tdata_i[31:0] !== due_beat.word) begin
            fail_count_o++;
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, due_beat.word, m_axis_tdata_i[31:0]);
          end
          if (m_axis_tdata_i[34:32] !== due_beat.index) begin
            fail_count_o++;
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, due_beat.index, m_axis_tdata_i[34:32]);
          end
          if (m_axis_tlast_i !== due_beat.last) begin
            fail_count_o++;
            $display("%0t: last_word mismatch: expected %b, actual %b",
                     $time, due_beat.last, m_axis_tlast_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        take_message_beat(s_axis_tdata_i[31:0], s_axis_tdata_i[34:32], s_axis_tlast_i);
      end
      digest_pending_o = digest_due_q.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the SHA-1 engine: clock, reset, message stimulus, back-pressure, verdict.
module tb_top;

  localparam int HoldCycles    = 400;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 200;
  localparam int RandomItems   = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int fail_count;
  int digest_pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  sha1_hash_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  sha1_digest_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tlast_i   (s_axis_tlast_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tlast_i   (m_axis_tlast_o),
    .fail_count_o     (fail_count),
    .digest_pending_o (digest_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // digest side: random stalls, long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [31:0] word, input logic [2:0] nbytes, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, nbytes, word};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_message(input int full_words, input logic [2:0] last_bytes);
    for (int i = 0; i < full_words; i++) begin
      send_beat($urandom, 3'($urandom_range(0, 7)), 1'b0);
    end
    send_beat($urandom, last_bytes, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (digest_pending != 0);
  endtask

  initial begin
    int phase_end;
    int msg_len;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty message, stray low bytes, oversized count
    send_beat(32'h0000_0000, 3'd0, 1'b1);
    send_beat(32'h6162_63ff, 3'd3, 1'b1);
    send_beat(32'hffff_ffff, 3'd7, 1'b1);
    send_beat(32'hffff_ffff, 3'd5, 1'b1);
    // short count on a non-final beat
    send_beat(32'h0000_0000, 3'd0, 1'b0);
    send_beat(32'hffff_ffff, 3'd4, 1'b1);
    send_beat(32'h8000_0001, 3'd1, 1'b1);
    send_beat(32'h1234_5678, 3'd2, 1'b1);
    wait_drained();
    // padding spills into an extra block
    send_message(13, 3'd4);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase == 0) hold_reqs++;
      phase_end = items_sent + RandomItems / 3;
      while (items_sent < phase_end) begin
        msg_len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 20) : $urandom_range(21, 47);
        send_message(msg_len, 3'($urandom_range(0, 7)));
      end
      wait_drained();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && digest_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sha1_pkg.sv
rtl/sha1_sched.sv
rtl/sha1_round.sv
rtl/sha1_hash_engine.sv
dv/sha1_digest_checker.sv
dv/tb_top.sv
